### sv/clfm_pkg.sv
// package for the clustering f-measure block
// holds default widths and the sequencer state type; no dependencies

package clfm_pkg;

	localparam int COUNT_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCORE,
		ST_SCORE_WAIT,
		ST_UPDATE,
		ST_MUL,
		ST_ACC,
		ST_FINAL,
		ST_FINAL_WAIT,
		ST_OUT
	} clfm_state_t;

endpackage

### sv/clfm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on clfm_pkg for default widths

module clfm_div #(
	parameter int COUNT_BITS    = clfm_pkg::COUNT_BITS_DEF,
	parameter int FRACTION_BITS = clfm_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COUNT_BITS:0]      rem_init,
	input  logic [FRACTION_BITS-1:0] lo_bits,
	input  logic [COUNT_BITS:0]      divisor,
	output logic                     done,
	output logic [FRACTION_BITS-1:0] quotient
);

	localparam int CNT_W = $clog2(FRACTION_BITS);

	logic [COUNT_BITS:0]      rem_q;
	logic [FRACTION_BITS-1:0] lo_q;
	logic [COUNT_BITS:0]      div_q;
	logic [FRACTION_BITS-1:0] quot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [COUNT_BITS+1:0]    trial;
	logic [COUNT_BITS+1:0]    diff;
	logic                     fits;

	// remainder stays below the divisor, so the difference fits back in place
	assign trial = {rem_q, lo_q[FRACTION_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRACTION_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			lo_q   <= lo_bits;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[COUNT_BITS:0] : trial[COUNT_BITS:0];
			lo_q   <= {lo_q[FRACTION_BITS-2:0], 1'b0};
			quot_q <= {quot_q[FRACTION_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

### sv/clustering_f_measure.sv
// top level of the clustering f-measure block
// depends on clfm_pkg and clfm_div

// Scores a contingency table streamed cell by cell, column by column. Each
// nonzero cell gets 2*cell/(row_total+column_total) in Q1.FRACTION_BITS,
// capped at 1.0; the best score of a column is weighted by its column total
// and summed, and table_end returns sum/total_items, capped at 1.0, as one
// f_measure transfer (0 when total_items is 0). One input transfer is taken
// at a time: a cell passes the score and update states, one that closes a
// column also multiply and accumulate, and a table end then the final
// ratio; the one bit-per-cycle divider serves both cell score and final
// ratio. Cells that are zero or saturate skip the divider. A finished result
// waits in the output register while the next cell is accepted. cfg_ready
// is always high; write total_items only while the block is idle.

module clustering_f_measure #(
	parameter int COUNT_BITS    = clfm_pkg::COUNT_BITS_DEF,
	parameter int FRACTION_BITS = clfm_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [COUNT_BITS-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [COUNT_BITS-1:0]    cell_count,
	input  logic [COUNT_BITS-1:0]    row_total,
	input  logic [COUNT_BITS-1:0]    column_total,
	input  logic                     column_end,
	input  logic                     table_end,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [FRACTION_BITS:0]   f_measure
);

	localparam int SUM_W = COUNT_BITS + FRACTION_BITS + 1;
	localparam logic [FRACTION_BITS:0] ONE_FIXED = {1'b1, {FRACTION_BITS{1'b0}}};

	clfm_pkg::clfm_state_t state_q, state_nxt;

	logic [COUNT_BITS-1:0]    total_q;
	logic [COUNT_BITS-1:0]    cell_q;
	logic [COUNT_BITS-1:0]    row_q;
	logic [COUNT_BITS-1:0]    col_q;
	logic                     cend_q;
	logic                     tend_q;
	logic [FRACTION_BITS:0]   score_q;
	logic [FRACTION_BITS:0]   best_q;
	logic [SUM_W-1:0]         prod_q;
	logic [SUM_W-1:0]         sum_q;
	logic [FRACTION_BITS:0]   res_q;
	logic [FRACTION_BITS:0]   out_q;
	logic                     out_valid_q;

	logic [COUNT_BITS:0]      den;
	logic [COUNT_BITS:0]      twice_cell;
	logic [COUNT_BITS:0]      sum_hi;
	logic                     score_zero;
	logic                     score_sat;
	logic                     fin_zero;
	logic                     fin_sat;
	logic                     out_free;
	logic [SUM_W:0]           acc;
	logic [SUM_W-1:0]         prod_c;

	logic                     div_start;
	logic                     div_final;
	logic [COUNT_BITS:0]      div_rem;
	logic [FRACTION_BITS-1:0] div_lo;
	logic [COUNT_BITS:0]      div_divisor;
	logic                     div_done;
	logic [FRACTION_BITS-1:0] div_quot;

	assign den        = {1'b0, row_q} + {1'b0, col_q};
	assign twice_cell = {cell_q, 1'b0};
	assign sum_hi     = sum_q[SUM_W-1:FRACTION_BITS];
	assign score_zero = cell_q == '0;
	// ratio reaches one, also covers both totals zero
	assign score_sat  = twice_cell >= den;
	assign fin_zero   = total_q == '0;
	assign fin_sat    = sum_hi >= {1'b0, total_q};
	assign out_free   = !out_valid_q || !out_stall;
	assign prod_c     = best_q * col_q;
	assign acc        = {1'b0, sum_q} + {1'b0, prod_q};

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			clfm_pkg::ST_IDLE:
				if (in_valid) state_nxt = clfm_pkg::ST_SCORE;
			clfm_pkg::ST_SCORE:
				state_nxt = (score_zero || score_sat) ? clfm_pkg::ST_UPDATE
				                                      : clfm_pkg::ST_SCORE_WAIT;
			clfm_pkg::ST_SCORE_WAIT:
				if (div_done) state_nxt = clfm_pkg::ST_UPDATE;
			clfm_pkg::ST_UPDATE:
				state_nxt = (cend_q || tend_q) ? clfm_pkg::ST_MUL : clfm_pkg::ST_IDLE;
			clfm_pkg::ST_MUL:
				state_nxt = clfm_pkg::ST_ACC;
			clfm_pkg::ST_ACC:
				state_nxt = tend_q ? clfm_pkg::ST_FINAL : clfm_pkg::ST_IDLE;
			clfm_pkg::ST_FINAL:
				state_nxt = (fin_zero || fin_sat) ? clfm_pkg::ST_OUT
				                                  : clfm_pkg::ST_FINAL_WAIT;
			clfm_pkg::ST_FINAL_WAIT:
				if (div_done) state_nxt = clfm_pkg::ST_OUT;
			clfm_pkg::ST_OUT:
				if (out_free) state_nxt = clfm_pkg::ST_IDLE;
			default:
				state_nxt = clfm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		div_final = 1'b0;
		case (state_q)
			clfm_pkg::ST_IDLE:
				in_stall = 1'b0;
			clfm_pkg::ST_SCORE:
				div_start = !score_zero && !score_sat;
			clfm_pkg::ST_FINAL: begin
				div_start = !fin_zero && !fin_sat;
				div_final = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign div_rem     = div_final ? sum_hi : twice_cell;
	assign div_lo      = div_final ? sum_q[FRACTION_BITS-1:0] : '0;
	assign div_divisor = div_final ? {1'b0, total_q} : den;

	clfm_div #(
		.COUNT_BITS    (COUNT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.lo_bits  (div_lo),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clfm_pkg::ST_IDLE;
			total_q     <= COUNT_BITS'(1);
			best_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) total_q <= cfg_data;
			if (state_q == clfm_pkg::ST_UPDATE && score_q > best_q) best_q <= score_q;
			if (state_q == clfm_pkg::ST_MUL) best_q <= '0;
			if (state_q == clfm_pkg::ST_ACC)
				sum_q <= acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
			if (state_q == clfm_pkg::ST_OUT && out_free) begin
				sum_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == clfm_pkg::ST_IDLE && in_valid) begin
			cell_q <= cell_count;
			row_q  <= row_total;
			col_q  <= column_total;
			cend_q <= column_end;
			tend_q <= table_end;
		end
		if (state_q == clfm_pkg::ST_SCORE)
			score_q <= score_zero ? '0 : ONE_FIXED;
		if (state_q == clfm_pkg::ST_SCORE_WAIT && div_done)
			score_q <= {1'b0, div_quot};
		if (state_q == clfm_pkg::ST_MUL)
			prod_q <= prod_c;
		if (state_q == clfm_pkg::ST_FINAL)
			res_q <= fin_zero ? '0 : ONE_FIXED;
		if (state_q == clfm_pkg::ST_FINAL_WAIT && div_done)
			res_q <= {1'b0, div_quot};
		if (state_q == clfm_pkg::ST_OUT && out_free)
			out_q <= res_q;
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign f_measure = out_q;

endmodule
